FILE: rtl/rgbd_pkg.sv
// Shared types and constants for the RGB difference magnitude statistics block.
package rgbd_pkg;

   localparam int CH_W       = 8;
   localparam int DIST_W     = 9;
   localparam int SUMSQ_W    = 18;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 112;
   localparam int TOTAL_W    = 23;
   localparam int DSUM_W     = 31;
   localparam int MEAN_W     = 17;
   localparam int VAR_W      = 25;
   localparam int QUO_W      = 25;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              last;
   } entry_type;

   typedef struct packed {
      logic                  full;
      logic                  empty;
      logic [FIFO_PTR_W:0]   level;
   } fifo_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SUM,
      F_ROOT,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ACC,
      B_MUL_A,
      B_MUL_B,
      B_DIV_MEAN,
      B_DIV_VAR,
      B_OUT
   } back_state_type;

endpackage

FILE: rtl/rgbd_front.sv
// Front end: accepts a pixel word and finds its distance with a bit-serial square root.
module rgbd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rgbd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   output rgbd_pkg::entry_type                 push_entry,
   output logic                                push_valid,
   input  logic                                push_ready
);

   rgbd_pkg::front_state_type state_ff, state_in;

   logic [15:0]                      sq0_ff, sq1_ff, sq2_ff;
   logic [15:0]                      sq0_in, sq1_in, sq2_in;
   logic [rgbd_pkg::SUMSQ_W-1:0]     val_ff, val_in;
   logic [rgbd_pkg::DIST_W-1:0]      root_ff, root_in;
   logic [rgbd_pkg::DIST_W-1:0]      bit_ff, bit_in;
   logic                             last_ff, last_in;
   logic [rgbd_pkg::DIST_W-1:0]      trial;
   logic [rgbd_pkg::SUMSQ_W-1:0]     trial_sq;
   logic [rgbd_pkg::CH_W-1:0]        ch0, ch1, ch2;

   assign ch0      = req_tdata[7:0];
   assign ch1      = req_tdata[15:8];
   assign ch2      = req_tdata[23:16];
   assign trial    = root_ff | bit_ff;
   assign trial_sq = rgbd_pkg::SUMSQ_W'(trial) * rgbd_pkg::SUMSQ_W'(trial);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rgbd_pkg::F_IDLE: begin
            if (req_tvalid) state_in = rgbd_pkg::F_SUM;
         end
         rgbd_pkg::F_SUM: state_in = rgbd_pkg::F_ROOT;
         rgbd_pkg::F_ROOT: begin
            if (bit_ff[0]) state_in = rgbd_pkg::F_PUSH;
         end
         rgbd_pkg::F_PUSH: begin
            if (push_ready) state_in = rgbd_pkg::F_IDLE;
         end
         default: state_in = rgbd_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      push_valid = 1'b0;
      sq0_in     = sq0_ff;
      sq1_in     = sq1_ff;
      sq2_in     = sq2_ff;
      val_in     = val_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      last_in    = last_ff;
      case (state_ff)
         rgbd_pkg::F_IDLE: begin
            req_tready = 1'b1;
            sq0_in     = 16'(ch0) * 16'(ch0);
            sq1_in     = 16'(ch1) * 16'(ch1);
            sq2_in     = 16'(ch2) * 16'(ch2);
            last_in    = req_tlast;
         end
         rgbd_pkg::F_SUM: begin
            val_in  = rgbd_pkg::SUMSQ_W'(sq0_ff) + rgbd_pkg::SUMSQ_W'(sq1_ff)
                      + rgbd_pkg::SUMSQ_W'(sq2_ff);
            root_in = '0;
            bit_in  = {1'b1, {(rgbd_pkg::DIST_W-1){1'b0}}};
         end
         rgbd_pkg::F_ROOT: begin
            if (trial_sq <= val_ff) root_in = trial;
            bit_in = bit_ff >> 1;
         end
         rgbd_pkg::F_PUSH: push_valid = 1'b1;
         default: ;
      endcase
   end

   assign push_entry.distance = root_ff;
   assign push_entry.last     = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgbd_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sq0_ff  <= sq0_in;
      sq1_ff  <= sq1_in;
      sq2_ff  <= sq2_in;
      val_ff  <= val_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      last_ff <= last_in;
   end

endmodule

FILE: rtl/rgbd_fifo.sv
// Short queue of distance entries between the front end and the statistics back end.
module rgbd_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  rgbd_pkg::entry_type        push_entry,
   input  logic                       push_valid,
   output logic                       push_ready,
   output rgbd_pkg::entry_type        pop_entry,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output rgbd_pkg::fifo_status_type  status
);

   rgbd_pkg::entry_type                mem_ff [rgbd_pkg::FIFO_DEPTH];
   logic [rgbd_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rgbd_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rgbd_pkg::FIFO_PTR_W:0]      level_ff, level_in;
   logic                               do_push, do_pop;

   assign status.full  = (level_ff == (rgbd_pkg::FIFO_PTR_W+1)'(rgbd_pkg::FIFO_DEPTH));
   assign status.empty = (level_ff == '0);
   assign status.level = level_ff;
   assign push_ready   = !status.full;
   assign pop_valid    = !status.empty;
   assign pop_entry    = mem_ff[rd_ptr_ff];
   assign do_push      = push_valid && push_ready;
   assign do_pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rgbd_pkg::FIFO_PTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + rgbd_pkg::FIFO_PTR_W'(do_pop);
      level_in  = level_ff + (rgbd_pkg::FIFO_PTR_W+1)'(do_push)
                  - (rgbd_pkg::FIFO_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

FILE: rtl/rgbd_back.sv
// Back end: frame accumulation, serial products, shared divider and the result register.
module rgbd_back #(
   parameter int MAX_FRAME_PIXELS = 4194304
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rgbd_pkg::entry_type                pop_entry,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   output logic [rgbd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);

   localparam int CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
   localparam int SUM_W  = $clog2(64'(MAX_FRAME_PIXELS) * 64'd441 + 64'd1);
   localparam int SQ_W   = $clog2(64'(MAX_FRAME_PIXELS) * 64'd194481 + 64'd1);
   localparam int PROD_W = (CNT_W + SQ_W > 2 * SUM_W) ? CNT_W + SQ_W : 2 * SUM_W;
   localparam int NUM_W  = PROD_W + 8;
   localparam int DEN_W  = 2 * CNT_W;
   localparam int STEP_W = $clog2(NUM_W);

   rgbd_pkg::back_state_type state_ff, state_in;

   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [SUM_W-1:0]                 sum_ff, sum_in;
   logic [SQ_W-1:0]                  sq_ff, sq_in;
   logic [rgbd_pkg::DIST_W-1:0]      dist_ff, dist_in;
   logic                             last_ff, last_in;
   logic [rgbd_pkg::SUMSQ_W-1:0]     dsq_ff, dsq_in;
   logic [PROD_W-1:0]                prod_ff, prod_in;
   logic [PROD_W-1:0]                mcand_ff, mcand_in;
   logic [SUM_W-1:0]                 mlt_ff, mlt_in;
   logic [PROD_W-1:0]                a_ff, a_in;
   logic [PROD_W-1:0]                b_ff, b_in;
   logic [DEN_W-1:0]                 den_ff, den_in;
   logic [NUM_W-1:0]                 num_ff, num_in;
   logic [DEN_W-1:0]                 rem_ff, rem_in;
   logic [rgbd_pkg::QUO_W-1:0]       quo_ff, quo_in;
   logic [rgbd_pkg::MEAN_W-1:0]      mean_ff, mean_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rgbd_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_user_ff, rsp_user_in;

   logic [PROD_W-1:0]                prod_step;
   logic [DEN_W-1:0]                 divisor;
   logic [DEN_W:0]                   trial;
   logic                             ge;
   logic [DEN_W-1:0]                 rem_step;
   logic [rgbd_pkg::QUO_W-1:0]       quo_step;
   logic                             room;
   logic                             has_var;
   logic                             single;
   logic [63:0]                      count_wide, sum_wide;

   assign prod_step = (prod_ff << 1) + (mlt_ff[SUM_W-1] ? mcand_ff : '0);
   assign divisor   = (state_ff == rgbd_pkg::B_DIV_VAR) ? den_ff : DEN_W'(count_ff);
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign ge        = trial >= {1'b0, divisor};
   assign rem_step  = ge ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
   assign quo_step  = {quo_ff[rgbd_pkg::QUO_W-2:0], ge};
   assign room      = !rsp_valid_ff || rsp_tready;
   assign has_var   = (count_ff >= CNT_W'(2)) && (a_ff >= b_ff);
   assign single    = (count_ff == CNT_W'(1));
   assign count_wide = 64'(count_ff);
   assign sum_wide   = 64'(sum_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rgbd_pkg::B_IDLE: begin
            if (pop_valid) state_in = rgbd_pkg::B_ACC;
         end
         rgbd_pkg::B_ACC: state_in = last_ff ? rgbd_pkg::B_MUL_A : rgbd_pkg::B_OUT;
         rgbd_pkg::B_MUL_A: begin
            if (step_ff == '0) state_in = rgbd_pkg::B_MUL_B;
         end
         rgbd_pkg::B_MUL_B: begin
            if (step_ff == '0) state_in = rgbd_pkg::B_DIV_MEAN;
         end
         rgbd_pkg::B_DIV_MEAN: begin
            if (step_ff == '0) state_in = has_var ? rgbd_pkg::B_DIV_VAR : rgbd_pkg::B_OUT;
         end
         rgbd_pkg::B_DIV_VAR: begin
            if (step_ff == '0) state_in = rgbd_pkg::B_OUT;
         end
         rgbd_pkg::B_OUT: begin
            if (room) state_in = rgbd_pkg::B_IDLE;
         end
         default: state_in = rgbd_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop_ready    = 1'b0;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      dist_in      = dist_ff;
      last_in      = last_ff;
      dsq_in       = dsq_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      mlt_in       = mlt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      mean_in      = mean_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         rgbd_pkg::B_IDLE: begin
            pop_ready = 1'b1;
            dist_in   = pop_entry.distance;
            last_in   = pop_entry.last;
            dsq_in    = rgbd_pkg::SUMSQ_W'(pop_entry.distance)
                        * rgbd_pkg::SUMSQ_W'(pop_entry.distance);
         end
         rgbd_pkg::B_ACC: begin
            if (count_ff < CNT_W'(MAX_FRAME_PIXELS)) begin
               count_in = count_ff + CNT_W'(1);
               sum_in   = sum_ff + SUM_W'(dist_ff);
               sq_in    = sq_ff + SQ_W'(dsq_ff);
            end
            mlt_in   = SUM_W'(count_in);
            mcand_in = PROD_W'(sq_in);
            prod_in  = '0;
            step_in  = STEP_W'(SUM_W - 1);
         end
         rgbd_pkg::B_MUL_A: begin
            den_in  = DEN_W'(count_ff) * DEN_W'(count_ff - CNT_W'(1));
            prod_in = prod_step;
            mlt_in  = mlt_ff << 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               a_in     = prod_step;
               mlt_in   = sum_ff;
               mcand_in = PROD_W'(sum_ff);
               prod_in  = '0;
               step_in  = STEP_W'(SUM_W - 1);
            end
         end
         rgbd_pkg::B_MUL_B: begin
            prod_in = prod_step;
            mlt_in  = mlt_ff << 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               b_in    = prod_step;
               num_in  = NUM_W'(sum_ff) << 8;
               rem_in  = '0;
               quo_in  = '0;
               step_in = STEP_W'(NUM_W - 1);
            end
         end
         rgbd_pkg::B_DIV_MEAN: begin
            num_in  = num_ff << 1;
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               mean_in = quo_step[rgbd_pkg::MEAN_W-1:0];
               num_in  = {a_ff - b_ff, 8'd0};
               rem_in  = '0;
               quo_in  = '0;
               step_in = STEP_W'(NUM_W - 1);
            end
         end
         rgbd_pkg::B_DIV_VAR: begin
            num_in  = num_ff << 1;
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff - STEP_W'(1);
         end
         rgbd_pkg::B_OUT: begin
            if (room) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  rsp_user_in = single;
                  rsp_data_in = {7'd0,
                                 quo_ff[rgbd_pkg::VAR_W-1:0],
                                 mean_ff,
                                 sum_wide[rgbd_pkg::DSUM_W-1:0],
                                 count_wide[rgbd_pkg::TOTAL_W-1:0],
                                 dist_ff};
                  count_in = '0;
                  sum_in   = '0;
                  sq_in    = '0;
               end else begin
                  rsp_user_in = 1'b0;
                  rsp_data_in = {(rgbd_pkg::RSP_DATA_W-rgbd_pkg::DIST_W)'(0), dist_ff};
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rgbd_pkg::B_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      last_ff     <= last_in;
      dsq_ff      <= dsq_in;
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      mlt_ff      <= mlt_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      mean_ff     <= mean_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

FILE: rtl/rgb_diff_magnitude_frame_stats_top.sv
// Top level of the RGB difference magnitude block with per-frame statistics.
//
//   Channel  Direction  Carries
//   req_     in         one pixel word: three channel differences, frame end on tlast
//   rsp_     out        one result word per pixel: distance, and frame statistics on tlast
//
// The front end works on one pixel at a time: it takes no new pixel until its bit-serial
// square root is done and the distance is pushed. A non-final pixel passes the back end's
// idle, accumulate and output states. The frame's last pixel adds two shift-add products
// and one or two divisions, during which the queue and the front end keep filling.
// Reset is synchronous and clears the frame sums. A stalled result holds in its register.
module rgb_diff_magnitude_frame_stats_top #(
   parameter int MAX_FRAME_PIXELS = 4194304
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: diff_ch0 [7:0], diff_ch1 [15:8], diff_ch2 [23:16]
   input  logic [rgbd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: distance [8:0], pixel_total [31:9], dist_total [62:32],
   // mean_q8 [79:63], variance_q8 [104:80], zero fill [111:105]
   output logic [rgbd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // rsp_tuser: single_pixel [0]
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready
);

   rgbd_pkg::entry_type        push_entry, pop_entry;
   logic                       push_valid, push_ready;
   logic                       pop_valid, pop_ready;
   rgbd_pkg::fifo_status_type  fifo_status;

   rgbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   rgbd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .status     (fifo_status)
   );

   rgbd_back #(
      .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

`ifndef NO_ASSERTIONS
   single_frame_stats_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[104:80] == '0)
                                  && (rsp_tdata[31:9] == 23'd1))
      else $error("single pixel frame reported with bad statistics");

   plain_word_clean_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[111:9] == '0) && !rsp_tuser)
      else $error("statistics fields set on a word that ends no frame");

   queue_level_a: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= (rgbd_pkg::FIFO_PTR_W+1)'(rgbd_pkg::FIFO_DEPTH))
      else $error("distance queue level beyond its depth");
`endif

endmodule
